// ===== design/multichannel_scalar_kalman_assert.svh =====
// assertion macros used by the kalman filter top level
// expects clk and rst_n in the scope where a macro is used
`ifndef MULTICHANNEL_SCALAR_KALMAN_ASSERT_SVH
`define MULTICHANNEL_SCALAR_KALMAN_ASSERT_SVH

// same-cycle implication, checked out of reset
`define MSK_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define MSK_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/msk_pkg.sv =====
// shared types and constants for the multichannel scalar kalman filter
// no dependencies; imported by every rtl module of the block
package msk_pkg;

  // field widths
  localparam int CH_W       = 3;
  localparam int MEAS_W     = 24;
  localparam int EST_W      = 24;
  localparam int COV_W      = 24;
  localparam int CFG_W      = 24;
  localparam int GAIN_W     = 16;
  localparam int IN_TDATA_W = 32;
  localparam int CFG_ADDR_W = 1;

  // serial datapath widths
  localparam int DEN_W      = COV_W + 1;
  localparam int MUL_A_W    = MEAS_W + 1;
  localparam int MUL_B_W    = GAIN_W + 1;

  // defaults
  localparam int CHANNELS_DEF = 8;

  // register reset values, unsigned q8.16
  localparam logic [CFG_W-1:0] PROCESS_NOISE_RST     = 24'd524;
  localparam logic [CFG_W-1:0] MEASUREMENT_NOISE_RST = 24'd655360;

  // gain constants: maximum gain in q0.16, one in q1.16
  localparam logic [GAIN_W-1:0]  GAIN_MAX = '1;
  localparam logic [MUL_B_W-1:0] ONE_Q16  = 17'h10000;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_PROCESS_NOISE     = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_MEASUREMENT_NOISE = 1'b1;

  // per-channel stored state
  typedef struct packed {
    logic signed [EST_W-1:0] estimate;
    logic [COV_W-1:0]        covariance;
  } chan_state_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_DIV,
    S_MUL,
    S_FIN
  } msk_state_t;

endpackage

// ===== design/multichannel_scalar_kalman.sv =====
// multichannel scalar kalman filter, top level
// uses msk_pkg, msk_mem, msk_div, msk_mul and the assertion macro header
//
//   port group  dir  transaction   contents
//   in_*        in   tvalid/tready channel, measurement (q15.8)
//   out_*       out  tvalid/tready estimate (q15.8, saturated)
//   cfg_*       in   cfg_we        register index, 24-bit value
//
// an in-range item goes from accept through one memory read, the divider (a start
// step, then one step per quotient bit) and both multipliers (a start step, then
// one step per multiplier bit), then write-back once the output register is free
// an out-of-range channel skips the math and returns its measurement without write-back
// rst_n is synchronous; it clears the valid bits so all channel state reads zero
// the next item is taken while a result waits in the output register;
// only a second finished result stalls until out_tready
module multichannel_scalar_kalman #(
  parameter int CHANNELS = msk_pkg::CHANNELS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [msk_pkg::IN_TDATA_W-1:0]      in_tdata,   // channel, measurement, zero pad
  // result channel
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [msk_pkg::EST_W-1:0]           out_tdata,  // estimate
  // configuration writes
  input  logic                                cfg_we,
  input  logic [msk_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [msk_pkg::CFG_W-1:0]           cfg_wdata
);
  import msk_pkg::*;

  `include "multichannel_scalar_kalman_assert.svh"

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int P_W = MUL_A_W + MUL_B_W;
  localparam logic signed [EST_W+2:0] EST_MAX = 27'sd8388607;
  localparam logic signed [EST_W+2:0] EST_MIN = -27'sd8388608;
  localparam logic signed [P_W-1:0]   RND_HALF = 42'sd32768;

  // configuration registers
  logic [CFG_W-1:0] process_noise_r;
  logic [CFG_W-1:0] measurement_noise_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      process_noise_r     <= PROCESS_NOISE_RST;
      measurement_noise_r <= MEASUREMENT_NOISE_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_PROCESS_NOISE:     process_noise_r     <= cfg_wdata;
        CFG_MEASUREMENT_NOISE: measurement_noise_r <= cfg_wdata;
      endcase
    end
  end

  // input fields
  logic [CH_W-1:0]          in_channel;
  logic signed [MEAS_W-1:0] in_measurement;
  logic                     in_acc;
  logic                     in_range;

  assign in_channel     = in_tdata[CH_W-1:0];
  assign in_measurement = in_tdata[CH_W+MEAS_W-1:CH_W];
  assign in_acc         = in_tvalid & in_tready;
  assign in_range       = (32'(in_channel) < 32'(CHANNELS));

  // sequencer and item registers
  msk_state_t               state_r, state_nxt;
  logic [AW-1:0]            chan_r;
  logic signed [MEAS_W-1:0] meas_r;
  logic                     pass_r;
  logic signed [EST_W-1:0]  prior_r;
  logic signed [MUL_A_W-1:0] diff_r;
  logic [COV_W-1:0]         ppred_r;
  logic                     rzero_r;
  logic                     out_valid_r;
  logic [EST_W-1:0]         out_data_r;

  // memory, divider and multipliers
  chan_state_t              rd_data;
  chan_state_t              wr_data;
  logic                     wr_en;
  logic                     div_start;
  logic                     div_done;
  logic [GAIN_W-1:0]        div_quot;
  logic                     mul_start;
  logic                     mul_e_done;
  logic                     mul_p_done;
  logic signed [P_W-1:0]    prod_e;
  logic signed [P_W-1:0]    prod_p;

  // prediction from the stored entry
  logic signed [EST_W-1:0]  prior;
  logic [COV_W:0]           cov_sum;
  logic [COV_W-1:0]         ppred;
  logic [DEN_W-1:0]         denom;

  assign prior   = (rd_data.estimate == '0) ? meas_r : rd_data.estimate;
  assign cov_sum = {1'b0, rd_data.covariance} + {1'b0, process_noise_r};
  assign ppred   = cov_sum[COV_W] ? '1 : cov_sum[COV_W-1:0];
  assign denom   = {1'b0, ppred} + {1'b0, measurement_noise_r};

  // gain, with the r = 0 cases forced
  logic [GAIN_W-1:0] gain;
  assign gain = rzero_r ? ((ppred_r != '0) ? GAIN_MAX : '0) : div_quot;

  // correction, rounding and saturation
  logic signed [P_W-1:0]     prod_rnd;
  logic signed [EST_W+2:0]   est_sum;
  logic signed [EST_W-1:0]   est_sat;
  logic [COV_W-1:0]          pnew;
  logic                      out_free;

  assign prod_rnd = prod_e + RND_HALF;
  assign est_sum  = (EST_W+3)'(prior_r) + (EST_W+3)'($signed(prod_rnd[P_W-1:GAIN_W]));
  assign est_sat  = (est_sum > EST_MAX) ? EST_MAX[EST_W-1:0] :
                    (est_sum < EST_MIN) ? EST_MIN[EST_W-1:0] : est_sum[EST_W-1:0];
  assign pnew     = prod_p[COV_W+GAIN_W-1:GAIN_W];
  assign out_free = !out_valid_r || out_tready;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and strobes
  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    div_start = 1'b0;
    mul_start = 1'b0;
    wr_en     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = in_range ? S_READ : S_FIN;
        end
      end
      S_READ: begin
        div_start = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          mul_start = 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        if (mul_e_done) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          wr_en     = !pass_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // item datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      chan_r <= AW'(in_channel);
      meas_r <= in_measurement;
    end
    if (state_r == S_READ) begin
      prior_r <= prior;
      diff_r  <= MUL_A_W'(meas_r) - MUL_A_W'(prior);
      ppred_r <= ppred;
      rzero_r <= (measurement_noise_r == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pass_r <= 1'b0;
    end else if (in_acc) begin
      pass_r <= !in_range;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_FIN && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_FIN && out_free) begin
      out_data_r <= pass_r ? meas_r : est_sat;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // write-back entry
  assign wr_data.estimate   = est_sat;
  assign wr_data.covariance = pnew;

  msk_mem #(
    .CHANNELS (CHANNELS),
    .AW       (AW)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_acc),
    .rd_addr (AW'(in_channel)),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (chan_r),
    .wr_data (wr_data)
  );

  msk_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (ppred),
    .den   (denom),
    .done  (div_done),
    .quot  (div_quot)
  );

  // gain times innovation
  msk_mul #(
    .A_W (MUL_A_W),
    .B_W (MUL_B_W)
  ) u_mul_est (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .mcand  (diff_r),
    .mplier ({1'b0, gain}),
    .done   (mul_e_done),
    .prod   (prod_e)
  );

  // (1 - gain) times predicted covariance
  msk_mul #(
    .A_W (MUL_A_W),
    .B_W (MUL_B_W)
  ) u_mul_cov (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .mcand  ({1'b0, ppred_r}),
    .mplier (ONE_Q16 - {1'b0, gain}),
    .done   (mul_p_done),
    .prod   (prod_p)
  );

  // checks
  `MSK_ASSERT_NOW(a_mul_in_step, 1'b1, mul_e_done == mul_p_done, "multipliers out of step")
  `MSK_ASSERT_NOW(a_div_done_state, div_done, state_r == S_DIV, "divider done outside wait")
  `MSK_ASSERT_NOW(a_wr_in_range, wr_en, !pass_r, "write-back for out-of-range channel")
  `MSK_ASSERT_NOW(a_cov_shrinks, wr_en, pnew <= ppred_r, "updated covariance above prediction")
  `MSK_ASSERT_NEXT(a_pass_skips, in_acc && !in_range, state_r == S_FIN, "bypass item entered math")

endmodule

// ===== design/msk_mem.sv =====
// per-channel state memory: one write port, one registered read port
// entries never written read as zero through per-entry valid bits; uses msk_pkg
module msk_mem #(
  parameter int CHANNELS = msk_pkg::CHANNELS_DEF,
  parameter int AW       = 3
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr,
  output msk_pkg::chan_state_t rd_data,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  msk_pkg::chan_state_t wr_data
);
  import msk_pkg::*;

  chan_state_t          mem [CHANNELS];
  chan_state_t          data_r;
  logic                 hit_r;
  logic [CHANNELS-1:0]  vld_r;

  // storage write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // valid bits, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else if (rd_en) begin
      hit_r <= vld_r[rd_addr];
    end
  end

  assign rd_data = hit_r ? data_r : '0;

endmodule

// ===== design/msk_div.sv =====
// restoring divider, one quotient bit per cycle, for the kalman gain
// computes floor(num * 2^16 / den) for num < den; uses msk_pkg
module msk_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [msk_pkg::COV_W-1:0]    num,
  input  logic [msk_pkg::DEN_W-1:0]    den,
  output logic                         done,
  output logic [msk_pkg::GAIN_W-1:0]   quot
);
  import msk_pkg::*;

  localparam int CNT_W = $clog2(GAIN_W + 1);

  logic [DEN_W-1:0]  rem_r;
  logic [DEN_W-1:0]  den_r;
  logic [GAIN_W-1:0] quot_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DEN_W:0]    shifted;
  logic              fits;

  // one trial subtraction per cycle
  assign shifted = {rem_r, 1'b0};
  assign fits    = (shifted >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= {1'b0, num};
      den_r  <= den;
      quot_r <= '0;
    end else if (busy_r) begin
      rem_r  <= fits ? DEN_W'(shifted - {1'b0, den_r}) : shifted[DEN_W-1:0];
      quot_r <= {quot_r[GAIN_W-2:0], fits};
    end
  end

  // step counter and done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(GAIN_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

// ===== design/msk_mul.sv =====
// shift-add multiplier, one multiplier bit per cycle
// signed multiplicand times unsigned multiplier; uses msk_pkg for defaults
module msk_mul #(
  parameter int A_W = msk_pkg::MUL_A_W,
  parameter int B_W = msk_pkg::MUL_B_W
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic signed [A_W-1:0]       mcand,
  input  logic [B_W-1:0]              mplier,
  output logic                        done,
  output logic signed [A_W+B_W-1:0]   prod
);
  import msk_pkg::*;

  localparam int P_W   = A_W + B_W;
  localparam int CNT_W = $clog2(B_W + 1);

  logic signed [P_W-1:0] acc_r;
  logic signed [P_W-1:0] mcand_r;
  logic [B_W-1:0]        mplier_r;
  logic [CNT_W-1:0]      cnt_r;
  logic                  busy_r;
  logic                  done_r;

  // partial product add and shift
  always_ff @(posedge clk) begin
    if (start) begin
      acc_r    <= '0;
      mcand_r  <= P_W'(mcand);
      mplier_r <= mplier;
    end else if (busy_r) begin
      if (mplier_r[0]) begin
        acc_r <= acc_r + mcand_r;
      end
      mcand_r  <= mcand_r <<< 1;
      mplier_r <= mplier_r >> 1;
    end
  end

  // step counter and done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(B_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

// ===== verif/testbench.sv =====
// self-checking testbench for the multichannel scalar kalman filter
// depends on msk_pkg and the multichannel_scalar_kalman rtl; runs a directed
// table, then randomized phases under several noise settings and random backpressure
`timescale 1ns / 100ps

module testbench;
  import msk_pkg::*;

  localparam int N_CH         = CHANNELS_DEF;
  localparam int N_DIRECTED   = 28;
  localparam int N_PHASES     = 6;
  localparam int PHASE_ITEMS  = 110;
  localparam int DRAIN_CYCLES = 40;

  // clock and reset
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // block ports, all driven to known values from time zero
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;   // channel, measurement, zero pad
  logic                  out_tvalid;
  logic                  out_tready = 1'b1;
  logic [EST_W-1:0]      out_tdata;       // estimate
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_W-1:0]      cfg_wdata = '0;

  multichannel_scalar_kalman DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // filter state as the testbench tracks it
  logic signed [EST_W-1:0] track_estimate [N_CH];
  logic [COV_W-1:0]        track_covariance [N_CH];
  logic [CFG_W-1:0]        track_q = PROCESS_NOISE_RST;
  logic [CFG_W-1:0]        track_r = MEASUREMENT_NOISE_RST;

  logic [EST_W-1:0] pending_estimates [$];
  int mismatches      = 0;
  int estimates_seen  = 0;
  int items_sent      = 0;
  int noise_settings  = 1;
  int burst_left      = 0;
  int ready_hold      = 0;
  int ready_roll;
  int channel_level [N_CH];

  // directed stimulus table
  typedef enum logic {ROW_MEAS, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    logic [CH_W-1:0]       ch;
    logic [CFG_ADDR_W-1:0] reg_idx;
    logic [CFG_W-1:0]      value;      // measurement or register value
    bit                    known;      // result typed in below
    logic [EST_W-1:0]      est;
  } stim_row_t;

  stim_row_t directed_rows [N_DIRECTED] = '{
    // empty channels: the first estimate is the measurement itself
    '{ROW_MEAS,  3'd0, CFG_PROCESS_NOISE,     24'h7FFFFF, 1'b1, 24'h7FFFFF},
    '{ROW_MEAS,  3'd1, CFG_PROCESS_NOISE,     24'h800000, 1'b1, 24'h800000},
    '{ROW_MEAS,  3'd2, CFG_PROCESS_NOISE,     24'h000000, 1'b1, 24'h000000},
    '{ROW_MEAS,  3'd2, CFG_PROCESS_NOISE,     24'h000000, 1'b1, 24'h000000},
    // full-scale swings against the stored estimate
    '{ROW_MEAS,  3'd0, CFG_PROCESS_NOISE,     24'h800000, 1'b0, 24'h000000},
    '{ROW_MEAS,  3'd1, CFG_PROCESS_NOISE,     24'h7FFFFF, 1'b0, 24'h000000},
    '{ROW_MEAS,  3'd3, CFG_PROCESS_NOISE,     24'h000100, 1'b1, 24'h000100},
    '{ROW_MEAS,  3'd3, CFG_PROCESS_NOISE,     24'h000200, 1'b0, 24'h000000},
    // maximum q, minimum r: gain close to one
    '{ROW_WRITE, 3'd0, CFG_PROCESS_NOISE,     24'hFFFFFF, 1'b0, 24'h000000},
    '{ROW_WRITE, 3'd0, CFG_MEASUREMENT_NOISE, 24'h000001, 1'b0, 24'h000000},
    '{ROW_MEAS,  3'd0, CFG_PROCESS_NOISE,     24'h7FFFFF, 1'b0, 24'h000000},
    '{ROW_MEAS,  3'd4, CFG_PROCESS_NOISE,     24'hFFFFFF, 1'b1, 24'hFFFFFF},
    '{ROW_MEAS,  3'd4, CFG_PROCESS_NOISE,     24'h000064, 1'b0, 24'h000000},
    '{ROW_MEAS,  3'd5, CFG_PROCESS_NOISE,     24'h000001, 1'b1, 24'h000001},
    // zero q, maximum r: small gain
    '{ROW_WRITE, 3'd0, CFG_PROCESS_NOISE,     24'h000000, 1'b0, 24'h000000},
    '{ROW_WRITE, 3'd0, CFG_MEASUREMENT_NOISE, 24'hFFFFFF, 1'b0, 24'h000000},
    '{ROW_MEAS,  3'd5, CFG_PROCESS_NOISE,     24'h800000, 1'b0, 24'h000000},
    '{ROW_MEAS,  3'd6, CFG_PROCESS_NOISE,     24'h7FFFFF, 1'b1, 24'h7FFFFF},
    '{ROW_MEAS,  3'd6, CFG_PROCESS_NOISE,     24'h800000, 1'b0, 24'h000000},
    // q and r both zero on an untouched channel: zero denominator, gain zero
    '{ROW_WRITE, 3'd0, CFG_MEASUREMENT_NOISE, 24'h000000, 1'b0, 24'h000000},
    '{ROW_MEAS,  3'd7, CFG_PROCESS_NOISE,     24'h0003E8, 1'b1, 24'h0003E8},
    '{ROW_MEAS,  3'd7, CFG_PROCESS_NOISE,     24'h001388, 1'b1, 24'h0003E8},
    // r zero with nonzero q: gain clamps just below one
    '{ROW_WRITE, 3'd0, CFG_PROCESS_NOISE,     24'h010000, 1'b0, 24'h000000},
    '{ROW_MEAS,  3'd7, CFG_PROCESS_NOISE,     24'h001388, 1'b0, 24'h000000},
    '{ROW_MEAS,  3'd3, CFG_PROCESS_NOISE,     24'hFFFED4, 1'b0, 24'h000000},
    // back to reset noise values
    '{ROW_WRITE, 3'd0, CFG_PROCESS_NOISE,     24'h00020C, 1'b0, 24'h000000},
    '{ROW_WRITE, 3'd0, CFG_MEASUREMENT_NOISE, 24'h0A0000, 1'b0, 24'h000000},
    '{ROW_MEAS,  3'd2, CFG_PROCESS_NOISE,     24'h000123, 1'b0, 24'h000000}
  };

  // one kalman update of a channel; returns the new estimate
  function automatic logic [EST_W-1:0] filter_step(input logic [CH_W-1:0] ch,
                                                   input logic signed [MEAS_W-1:0] meas);
    longint prior, ppred, denom, gain, diff, corr, nxt, pnew;
    prior = track_estimate[ch];
    // an all-zero estimate means the channel has no estimate yet
    if (prior == 0) prior = meas;
    ppred = longint'(track_covariance[ch]) + longint'(track_q);
    if (ppred > 64'hFFFFFF) ppred = 64'hFFFFFF;
    denom = ppred + longint'(track_r);
    gain = (denom == 0) ? 0 : (ppred << 16) / denom;
    if (gain > 65535) gain = 65535;
    diff = longint'(meas) - prior;
    // round to nearest, halves up
    corr = (gain * diff + 32768) >>> 16;
    nxt = prior + corr;
    if (nxt > 8388607) nxt = 8388607;
    else if (nxt < -8388608) nxt = -8388608;
    pnew = ((65536 - gain) * ppred) >>> 16;
    track_estimate[ch] = EST_W'(nxt);
    track_covariance[ch] = COV_W'(pnew);
    return EST_W'(nxt);
  endfunction

  // idle length: mostly none or short, sometimes long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // random measurement around the channel's current level
  function automatic logic [MEAS_W-1:0] pick_measurement(input int lvl);
    int r, v;
    logic [MEAS_W-1:0] raw;
    r = $urandom_range(0, 99);
    raw = MEAS_W'($urandom);
    if (r < 62) v = lvl + int'($urandom_range(0, 4000)) - 2000;
    else if (r < 78) return raw;
    else if (r < 85) return '0;
    else if (r < 89) v = 8388607 - int'($urandom_range(0, 300));
    else if (r < 93) v = -8388608 + int'($urandom_range(0, 300));
    else v = lvl;
    if (v > 8388607) v = 8388607;
    else if (v < -8388608) v = -8388608;
    return MEAS_W'(v);
  endfunction

  task automatic report_mismatch(input string what, input logic [EST_W-1:0] exp_est,
                                 input logic [EST_W-1:0] got_est);
    $display("[%0t] mismatch %s: expected %0d got %0d", $time, what,
             $signed(exp_est), $signed(got_est));
    mismatches++;
  endtask

  // optional gap after a transaction, with occasional gap-free bursts
  task automatic sender_gap();
    int n;
    n = 0;
    if (burst_left > 0) begin
      burst_left--;
    end else if ($urandom_range(0, 24) == 0) begin
      burst_left = 30;
    end else begin
      n = idle_len();
    end
    if (n > 0) begin
      in_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_measurement(input logic [CH_W-1:0] ch, input logic [MEAS_W-1:0] meas,
                                  input bit known, input logic [EST_W-1:0] known_est);
    logic [EST_W-1:0] predicted;
    in_tdata  <= {(IN_TDATA_W-CH_W-MEAS_W)'(0), meas, ch};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = filter_step(ch, meas);
    pending_estimates.push_back(known ? known_est : predicted);
    items_sent++;
    sender_gap();
  endtask

  // hold the input until every pending estimate has come back
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_estimates.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_W-1:0] val);
    drain();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_PROCESS_NOISE) track_q = val;
    else track_r = val;
  endtask

  // receiver: random stalls, short ready runs and long free stretches
  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold--;
    end else begin
      ready_roll = $urandom_range(0, 99);
      if (ready_roll < 20) begin
        out_tready <= 1'b0;
        ready_hold = idle_len();
      end else if (ready_roll < 24) begin
        out_tready <= 1'b1;
        ready_hold = 300;
      end else begin
        out_tready <= 1'b1;
        ready_hold = $urandom_range(0, 12);
      end
    end
  end

  // result check against the oldest pending estimate
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_estimates.size() == 0) begin
        report_mismatch("unexpected transaction", '0, out_tdata);
      end else begin
        if (out_tdata !== pending_estimates[0])
          report_mismatch("estimate", pending_estimates[0], out_tdata);
        void'(pending_estimates.pop_front());
        estimates_seen++;
      end
    end
  end

  // main sequence
  initial begin
    logic [CFG_W-1:0] q_val, r_val;
    logic [CH_W-1:0]  ch;
    for (int i = 0; i < N_CH; i++) begin
      track_estimate[i] = '0;
      track_covariance[i] = '0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    for (int i = 0; i < N_DIRECTED; i++) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        write_register(directed_rows[i].reg_idx, directed_rows[i].value);
        noise_settings++;
      end else begin
        send_measurement(directed_rows[i].ch, directed_rows[i].value,
                         directed_rows[i].known, directed_rows[i].est);
      end
    end

    // random phases, each under its own noise setting
    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0: begin q_val = PROCESS_NOISE_RST; r_val = MEASUREMENT_NOISE_RST; end
        1: begin
          q_val = CFG_W'($urandom_range(0, 4096));
          r_val = CFG_W'($urandom_range(1, 1 << 20));
        end
        2: begin q_val = 24'hFFFFFF; r_val = CFG_W'($urandom_range(1, 24'hFFFFFF)); end
        3: begin q_val = 24'h000000; r_val = 24'h000001; end
        4: begin
          q_val = CFG_W'($urandom_range(0, 24'hFFFFFF));
          r_val = CFG_W'($urandom_range(1, 24'hFFFFFF));
        end
        default: begin q_val = CFG_W'($urandom_range(0, 65536)); r_val = 24'hFFFFFF; end
      endcase
      write_register(CFG_PROCESS_NOISE, q_val);
      write_register(CFG_MEASUREMENT_NOISE, r_val);
      noise_settings++;
      // per-channel signal levels, some near zero so estimates cross it
      for (int c = 0; c < N_CH; c++) begin
        if ($urandom_range(0, 3) == 0)
          channel_level[c] = int'($urandom_range(0, 600)) - 300;
        else
          channel_level[c] = int'($urandom_range(0, 4000000)) - 2000000;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        ch = CH_W'($urandom_range(0, N_CH - 1));
        send_measurement(ch, pick_measurement(channel_level[ch]), 1'b0, '0);
        // now and then the sender holds until everything has come back
        if ($urandom_range(0, 49) == 0) drain();
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("run covered %0d measurements on %0d channels under %0d noise settings",
             items_sent, N_CH, noise_settings);
    $display("%0d estimates checked, %0d mismatches", estimates_seen, mismatches);
    if (mismatches == 0 && pending_estimates.size() == 0) begin
      $display("** multichannel_scalar_kalman: PASSED **");
    end else begin
      $display("** multichannel_scalar_kalman: FAILED **");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5000000;
    $display("watchdog expired with %0d estimates pending", pending_estimates.size());
    $display("** multichannel_scalar_kalman: FAILED **");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/msk_pkg.sv
design/msk_mem.sv
design/msk_div.sv
design/msk_mul.sv
design/multichannel_scalar_kalman.sv
verif/testbench.sv
